// ----- rtl/uleb_pkg.sv -----
package uleb_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_OVERLONG = 2'd2
  } kind_t;

  localparam logic [7:0]  CONT_BIT   = 8'h80;
  localparam logic [7:0]  GROUP_MASK = 8'h7F;
  localparam logic [2:0]  LAST_POS   = 3'd4;
  localparam int unsigned GROUP_W    = 7;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

// ----- rtl/uleb_dec.sv -----
module uleb_dec (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data,
  output logic          emit,
  output uleb_pkg::res_t res
);
  import uleb_pkg::*;

  logic [31:0] partial_value;
  logic [31:0] partial_value_next;
  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [6:0]  group;
  logic [31:0] placed;
  logic [31:0] merged;
  logic        at_last;
  logic        done;

  assign group   = data[6:0];
  assign at_last = (byte_count >= LAST_POS);
  assign done    = ((data & CONT_BIT) == 8'h00);

  // fifth byte keeps only the four group bits that fit under bit 32
  always_comb begin
    unique case (byte_count)
      3'd0:    placed = {25'b0, group};
      3'd1:    placed = {18'b0, group, 7'b0};
      3'd2:    placed = {11'b0, group, 14'b0};
      3'd3:    placed = {4'b0, group, 21'b0};
      default: placed = {group[3:0], 28'b0};
    endcase
  end

  assign merged = partial_value | placed;
  assign emit   = done || at_last;

  always_comb begin
    res.kind  = done ? KIND_VALUE : KIND_OVERLONG;
    res.data  = 8'h00;
    res.value = done ? merged : 32'h0;
    res.last  = 1'b1;
  end

  always_comb begin
    if (emit) begin
      partial_value_next = 32'h0;
      byte_count_next    = 3'd0;
    end else begin
      partial_value_next = merged;
      byte_count_next    = byte_count + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= 32'h0;
      byte_count    <= 3'd0;
    end else if (take) begin
      partial_value <= partial_value_next;
      byte_count    <= byte_count_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_POS)
    else $error("decode byte count out of range");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    take && emit |=> byte_count == 3'd0 && partial_value == 32'h0)
    else $error("decode state not cleared after result");

  a_overlong_pos: assert property (@(posedge clk) disable iff (rst)
    take && emit && !done |-> at_last)
    else $error("overlong flagged before fifth byte");

endmodule

// ----- rtl/uleb128_varint_codec_core.sv -----
// Channel | Beat                           | Handshake
// in      | mode, in_byte, in_value        | in_valid / in_stall
// out     | kind, out_byte, out_value, last| out_valid / out_stall
//
// One input register feeds one result register through short logic.
// Decode bytes and small encodes pass back to back unless the output stalls.
// An n-byte encode holds the input register, one byte per cycle unless stalled.
// rst is synchronous and clears both valid flags and the decode state.
// out_stall holds the result register; in_stall rises only while the
// held item still has results to deliver.
module uleb128_varint_codec_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  in_byte,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] out_value,
  output logic        last
);
  import uleb_pkg::*;

  logic        hold_valid;
  logic        hold_mode;
  logic [7:0]  hold_byte;
  logic [31:0] hold_value;

  logic        adv;
  logic        enc_final;
  logic        dec_emit;
  logic        consume;
  logic        produce;
  logic        accept;
  res_t        dec_res;
  res_t        enc_res;
  res_t        res;
  res_t        res_next;

  // result register can load when it is empty or being drained this cycle
  assign adv = !(out_valid && out_stall);

  assign enc_final = (hold_value[31:GROUP_W] == '0);

  uleb_dec u_dec (
    .clk  (clk),
    .rst  (rst),
    .take (hold_valid && !hold_mode && consume),
    .data (hold_byte),
    .emit (dec_emit),
    .res  (dec_res)
  );

  always_comb begin
    enc_res.kind  = KIND_BYTE;
    enc_res.data  = enc_final ? (hold_value[7:0] & GROUP_MASK)
                              : ((hold_value[7:0] & GROUP_MASK) | CONT_BIT);
    enc_res.value = 32'h0;
    enc_res.last  = enc_final;
  end

  assign res_next = hold_mode ? enc_res : dec_res;
  assign consume  = hold_valid && (hold_mode ? (adv && enc_final) : (!dec_emit || adv));
  assign produce  = hold_valid && adv && (hold_mode || dec_emit);
  assign in_stall = hold_valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_mode  <= mode;
      hold_byte  <= in_byte;
      hold_value <= in_value;
    end else if (produce && hold_mode) begin
      hold_value <= hold_value >> GROUP_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res <= res_next;
    end
  end

  assign kind      = res.kind;
  assign out_byte  = res.data;
  assign out_value = res.value;
  assign last      = res.last;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.kind != KIND_BYTE) |-> res.last)
    else $error("decode result without last");

  a_enc_blocks: assert property (@(posedge clk) disable iff (rst)
    hold_valid && hold_mode && !enc_final |-> in_stall)
    else $error("input taken while encode bytes remain");

  a_enc_final: assert property (@(posedge clk) disable iff (rst)
    produce && hold_mode && enc_final |=> out_valid && res.last)
    else $error("final encoded byte not flagged");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uleb_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  in_byte;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] out_value;
  logic        last;

  // decoder state mirrored for prediction
  logic [31:0] dec_acc = '0;
  logic [2:0]  dec_count = '0;
  res_t        expected_beats[$];

  int          fail_cnt = 0;
  int          idle_cycles = 0;
  bit          src_idle;
  bit          sink_idle;
  bit          hold_long;

  uleb128_varint_codec_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .in_byte   (in_byte),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .out_value (out_value),
    .last      (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void predict_codec(input logic m, input logic [7:0] b,
                                        input logic [31:0] v);
    res_t        r;
    int unsigned n;
    int unsigned k;
    logic [6:0]  g;
    logic [2:0]  pos;
    logic [31:0] grp;
    if (m) begin
      if (v < 32'h0000_0080) n = 1;
      else if (v < 32'h0000_4000) n = 2;
      else if (v < 32'h0020_0000) n = 3;
      else if (v < 32'h1000_0000) n = 4;
      else n = 5;
      for (k = 0; k < n; k++) begin
        g = 7'(v >> (GROUP_W * k));
        r.kind  = KIND_BYTE;
        r.data  = (k == n - 1) ? {1'b0, g} : (CONT_BIT | {1'b0, g});
        r.value = '0;
        r.last  = (k == n - 1);
        expected_beats.push_back(r);
      end
    end else begin
      pos = (dec_count > LAST_POS) ? LAST_POS : dec_count;
      // group bits above bit 31 fall off here
      grp = {25'd0, b[6:0]} << (GROUP_W * pos);
      dec_acc = dec_acc | grp;
      if (!b[7]) begin
        r.kind  = KIND_VALUE;
        r.data  = '0;
        r.value = dec_acc;
        r.last  = 1'b1;
        expected_beats.push_back(r);
        dec_acc   = '0;
        dec_count = '0;
      end else if (pos == LAST_POS) begin
        r.kind  = KIND_OVERLONG;
        r.data  = '0;
        r.value = '0;
        r.last  = 1'b1;
        expected_beats.push_back(r);
        dec_acc   = '0;
        dec_count = '0;
      end else begin
        dec_count = pos + 3'd1;
      end
    end
  endfunction

  function automatic void check_beat();
    res_t exp_r;
    if (expected_beats.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("unexpected beat: kind=%0d byte=%02h value=%08h last=%0b",
                 kind, out_byte, out_value, last);
    end else begin
      exp_r = expected_beats.pop_front();
      if (kind !== exp_r.kind || out_byte !== exp_r.data ||
          out_value !== exp_r.value || last !== exp_r.last) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display({"mismatch: exp kind=%0d byte=%02h value=%08h last=%0b,",
                    " got kind=%0d byte=%02h value=%08h last=%0b"},
                   exp_r.kind, exp_r.data, exp_r.value, exp_r.last,
                   kind, out_byte, out_value, last);
      end
    end
  endfunction

  // both channels sampled on the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_codec(mode, in_byte, in_value);
      if (out_valid && !out_stall) check_beat();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_item(input logic m, input logic [7:0] b, input logic [31:0] v);
    int unsigned gap;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    in_byte  <= b;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_dec(input logic [7:0] b);
    send_item(1'b0, b, $urandom);
  endtask

  task automatic send_enc(input logic [31:0] v);
    send_item(1'b1, 8'($urandom), v);
  endtask

  function automatic logic [31:0] rand_value();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 1) == 0) send_enc(rand_value());
    else send_dec(8'($urandom));
  endtask

  task automatic test_encode_bounds();
    send_enc(32'h0000_0000);
    send_enc(32'h0000_007F);
    send_enc(32'h0000_0080);
    send_enc(32'h0000_3FFF);
    send_enc(32'h0000_4000);
    send_enc(32'h0020_0000);
    send_enc(32'h1000_0000);
    send_enc(32'hFFFF_FFFF);
  endtask

  task automatic test_decode_cases();
    send_dec(8'h7F);
    // full five bytes, top group bits dropped
    repeat (4) send_dec(8'hFF);
    send_dec(8'h7F);
    // overlong, then a fresh value
    repeat (5) send_dec(8'h80 | 8'($urandom));
    send_dec(8'h00);
    // encode in the middle of a decode leaves it pending
    send_dec(8'h85);
    send_enc(32'd300);
    send_dec(8'h01);
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned len;
    int unsigned sel;
    int unsigned i;
    int unsigned phase_mark;
    sent = 0;
    phase_mark = 0;
    while (sent < 340) begin
      if (sent >= phase_mark) begin
        src_idle   = $urandom_range(0, 2) != 0;
        sink_idle  = $urandom_range(0, 2) != 0;
        phase_mark = sent + 50;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 9) == 0) begin
            send_enc(rand_value());
            sent++;
          end
          send_dec({i != len - 1, 7'($urandom)});
        end
        sent += len;
      end else if (sel < 8) begin
        send_enc(rand_value());
        sent++;
      end else if (sel == 8) begin
        repeat (5) send_dec(8'h80 | 8'($urandom));
        sent += 5;
      end else begin
        send_dec(8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    hold_long = 1'b1;
    repeat (10) send_enc(32'hF000_0000 | $urandom);
    repeat (20) send_random_item();
  endtask

  task automatic test_no_idle();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (30) send_random_item();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= 1'b0;
    in_byte   <= '0;
    in_value  <= '0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    hold_long = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_encode_bounds();
    test_decode_cases();
    test_random_streams();
    test_backpressure();
    test_no_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/uleb_pkg.sv
rtl/uleb_dec.sv
rtl/uleb128_varint_codec_core.sv
tb/sv/testbench.sv
